FILE: design/flvd_pkg.sv
// Shared types and constants for the FLV tag demultiplexer.
// No dependencies; the parser, the emitter and the top level import this package.
package flvd_pkg;

  localparam int unsigned FILE_HDR_LEN = 9;
  localparam int unsigned TAG_HDR_LEN  = 11;
  localparam int unsigned BACKPTR_LEN  = 4;
  localparam int unsigned REPLAY_LEN   = FILE_HDR_LEN + BACKPTR_LEN;

  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_SCRIPT = 8'd18;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_EN = 1'd1;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_VIDEO = 2'd1,
    KIND_TAG   = 2'd2,
    KIND_HDR   = 2'd3
  } kind_t;

  // Which results a job still owes, in the order they go out.
  typedef struct packed {
    logic hdr;
    logic info;
    logic audio;
    logic replay;
    logic video;
  } job_flags_t;

  typedef struct packed {
    logic        valid;
    job_flags_t  flags;
    logic [7:0]  data;
    logic [71:0] fh;        // file header, byte 0 most significant
    logic [7:0]  tag_kind;
    logic [23:0] payload_size;
    logic [23:0] tag_time;
    logic [31:0] tail_word;
  } job_t;

  function automatic logic reported_type(input logic [7:0] t);
    return (t == TAG_AUDIO) || (t == TAG_VIDEO) || (t == TAG_SCRIPT);
  endfunction

endpackage

FILE: design/flvd_in_if.sv
// Input channel of the FLV demultiplexer: one file byte per beat.
// Depends on nothing but the valid/ready convention.
interface flvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       start_of_file;

  modport source (output valid, output stream_byte, output start_of_file, input ready);
  modport sink   (input valid, input stream_byte, input start_of_file, output ready);
endinterface

FILE: design/flvd_out_if.sv
// Result channel of the FLV demultiplexer: one result item per beat.
// Depends on nothing but the valid/ready convention.
interface flvd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  out_byte;
  logic [7:0]  tag_kind;
  logic [23:0] payload_size;
  logic [23:0] tag_time;
  logic [31:0] tail_word;
  logic [7:0]  first_payload;
  logic [23:0] signature_bytes;
  logic [7:0]  format_version;
  logic [7:0]  header_flags;
  logic [31:0] data_start;
  logic        last_of_run;

  modport source (
    output valid, output result_kind, output out_byte, output tag_kind,
    output payload_size, output tag_time, output tail_word, output first_payload,
    output signature_bytes, output format_version, output header_flags,
    output data_start, output last_of_run, input ready
  );
  modport sink (
    input valid, input result_kind, input out_byte, input tag_kind,
    input payload_size, input tag_time, input tail_word, input first_payload,
    input signature_bytes, input format_version, input header_flags,
    input data_start, input last_of_run, output ready
  );
endinterface

FILE: design/flvd_parser.sv
// Byte parser: tracks the FLV structure and turns each input beat into a job
// that lists the results it causes. Depends on flvd_pkg and flvd_in_if.
module flvd_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  flvd_in_if.sink                            in_ch,
  input  logic                               cfg_we,
  input  logic [flvd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [flvd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output flvd_pkg::job_t                     job,
  input  logic                               job_ready
);
  import flvd_pkg::*;

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_SKIP,
    PH_PREV,
    PH_PREVV,
    PH_TAGHDR,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt, eff_phase;
  logic [31:0] cnt_r, cnt_nxt, eff_cnt;
  logic [23:0] pl_r, pl_nxt, eff_pl;
  logic        vs_r, vs_nxt, eff_vs;
  logic [71:0] fh_r, fh_nxt;
  logic [87:0] th_r, th_nxt;
  logic        audio_en_r, video_en_r;
  logic        accept;
  logic        video_req;
  logic [7:0]  b;
  logic [7:0]  tag0;
  logic [31:0] offset;
  logic [23:0] tag_sz;
  logic        first_byte;

  assign accept      = in_ch.valid && job_ready;
  assign in_ch.ready = job_ready;
  assign b           = in_ch.stream_byte;
  assign tag_sz      = th_r[79:56];

  always_comb begin
    if (in_ch.start_of_file) begin
      eff_phase = PH_FILEHDR;
      eff_cnt   = '0;
      eff_pl    = '0;
      eff_vs    = 1'b0;
    end else begin
      eff_phase = phase_r;
      eff_cnt   = cnt_r;
      eff_pl    = pl_r;
      eff_vs    = vs_r;
    end
  end

  always_comb begin
    phase_nxt  = eff_phase;
    cnt_nxt    = eff_cnt;
    pl_nxt     = eff_pl;
    vs_nxt     = eff_vs;
    fh_nxt     = fh_r;
    th_nxt     = th_r;
    video_req  = 1'b0;
    tag0       = th_r[87:80];
    offset     = '0;
    first_byte = 1'b0;
    job              = '0;
    job.data         = b;
    job.tag_kind     = th_r[87:80];
    job.payload_size = tag_sz;
    job.tag_time     = th_r[55:32];
    job.tail_word    = th_r[31:0];

    case (eff_phase)
      PH_FILEHDR: begin
        for (int i = 0; i < FILE_HDR_LEN; i++) begin
          if (eff_cnt[3:0] == 4'(i)) fh_nxt[71-8*i -: 8] = b;
        end
        cnt_nxt = eff_cnt + 32'd1;
        if (eff_cnt[3:0] == 4'(FILE_HDR_LEN - 1)) begin
          job.flags.hdr = 1'b1;
          offset = fh_nxt[31:0];
          // Offsets that point inside the header behave as if they pointed just past it.
          if (offset < 32'(FILE_HDR_LEN)) offset = 32'(FILE_HDR_LEN);
          cnt_nxt   = offset - 32'(FILE_HDR_LEN);
          phase_nxt = (cnt_nxt != '0) ? PH_SKIP : PH_PREV;
        end
      end
      PH_SKIP: begin
        cnt_nxt = eff_cnt - 32'd1;
        if (cnt_nxt == '0) phase_nxt = PH_PREV;
      end
      PH_PREV, PH_PREVV: begin
        // A nonzero payload_left here marks the info owed by a zero-size tag.
        if (eff_pl != '0 && eff_cnt == '0) begin
          job.flags.info = 1'b1;
          pl_nxt = '0;
        end
        video_req = (eff_phase == PH_PREVV);
        cnt_nxt   = eff_cnt + 32'd1;
        if (eff_cnt[1:0] == 2'(BACKPTR_LEN - 1)) begin
          cnt_nxt   = '0;
          pl_nxt    = '0;
          phase_nxt = PH_TAGHDR;
        end
      end
      PH_TAGHDR: begin
        for (int i = 0; i < TAG_HDR_LEN; i++) begin
          if (eff_cnt[3:0] == 4'(i)) th_nxt[87-8*i -: 8] = b;
        end
        tag0      = th_nxt[87:80];
        video_req = (tag0 == TAG_VIDEO);
        cnt_nxt   = eff_cnt + 32'd1;
        if (eff_cnt[3:0] == 4'(TAG_HDR_LEN - 1)) begin
          cnt_nxt = '0;
          pl_nxt  = th_nxt[79:56];
          if (pl_nxt != '0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            pl_nxt    = {23'd0, reported_type(tag0)};
            phase_nxt = (tag0 == TAG_VIDEO) ? PH_PREVV : PH_PREV;
          end
        end
      end
      PH_PAYLOAD: begin
        first_byte = (eff_pl == tag_sz);
        if (first_byte && reported_type(tag0)) job.flags.info = 1'b1;
        if (tag0 == TAG_AUDIO) begin
          job.flags.audio = !first_byte && audio_en_r;
        end else if (tag0 == TAG_VIDEO) begin
          video_req = 1'b1;
        end
        pl_nxt = eff_pl - 24'd1;
        if (pl_nxt == '0) begin
          cnt_nxt   = '0;
          phase_nxt = (tag0 == TAG_VIDEO) ? PH_PREVV : PH_PREV;
        end
      end
      default: begin
        phase_nxt = PH_FILEHDR;
      end
    endcase

    if (video_req && video_en_r) begin
      job.flags.video = 1'b1;
      if (!eff_vs) begin
        job.flags.replay = 1'b1;
        vs_nxt = 1'b1;
      end
    end
    job.fh    = fh_nxt;
    job.valid = in_ch.valid && (job.flags != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FILEHDR;
      cnt_r      <= '0;
      pl_r       <= '0;
      vs_r       <= 1'b0;
      audio_en_r <= 1'b0;
      video_en_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        pl_r    <= pl_nxt;
        vs_r    <= vs_nxt;
      end
      if (cfg_we && cfg_index == CFG_AUDIO_EN) audio_en_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == CFG_VIDEO_EN) video_en_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fh_r <= fh_nxt;
      th_r <= th_nxt;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> cnt_r != '0)
    else $error("offset skip phase entered with an empty count");
  a_taghdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TAGHDR |-> cnt_r < 32'(TAG_HDR_LEN))
    else $error("tag header position out of range");
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pl_r != '0)
    else $error("payload phase with nothing left to read");

endmodule

FILE: design/flvd_emitter.sv
// Result sequencer: holds one job and plays out its results, one per beat,
// into the output register. Depends on flvd_pkg and flvd_out_if.
module flvd_emitter (
  input  logic           clk,
  input  logic           rst_n,
  input  flvd_pkg::job_t job,
  output logic           job_ready,
  flvd_out_if.source     out_ch
);
  import flvd_pkg::*;

  job_t        job_r;
  logic        job_valid_r;
  logic [3:0]  rep_cnt_r;
  job_flags_t  rem;
  logic        emit;
  logic        last;
  logic [7:0]  rep_byte;

  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r;

  assign emit      = job_valid_r && (!out_valid_r || out_ch.ready);
  assign last      = (rem == '0);
  assign job_ready = !job_valid_r || (emit && last);

  always_comb begin
    rep_byte = '0;
    for (int i = 0; i < FILE_HDR_LEN; i++) begin
      if (rep_cnt_r == 4'(i)) rep_byte = job_r.fh[71-8*i -: 8];
    end
  end

  // Results go out in the order header info, tag info, audio, header replay, video.
  always_comb begin
    rem      = job_r.flags;
    kind_nxt = KIND_VIDEO;
    byte_nxt = '0;
    if (job_r.flags.hdr) begin
      kind_nxt = KIND_HDR;
      rem.hdr  = 1'b0;
    end else if (job_r.flags.info) begin
      kind_nxt = KIND_TAG;
      rem.info = 1'b0;
    end else if (job_r.flags.audio) begin
      kind_nxt  = KIND_AUDIO;
      byte_nxt  = job_r.data;
      rem.audio = 1'b0;
    end else if (job_r.flags.replay) begin
      byte_nxt = rep_byte;
      if (rep_cnt_r == 4'(REPLAY_LEN - 1)) rem.replay = 1'b0;
    end else begin
      byte_nxt  = job_r.data;
      rem.video = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      rep_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) begin
        job_valid_r <= job.valid;
        rep_cnt_r   <= '0;
      end else if (emit) begin
        // The count stops on the last replay beat.
        if (job_r.flags.replay && !job_r.flags.hdr && !job_r.flags.info
            && !job_r.flags.audio && rem.replay) begin
          rep_cnt_r <= rep_cnt_r + 4'd1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      job_r <= job;
    end else if (emit) begin
      job_r.flags <= rem;
    end
    if (emit) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      last_r <= last;
      out_ch.tag_kind        <= (kind_nxt == KIND_TAG) ? job_r.tag_kind : '0;
      out_ch.payload_size    <= (kind_nxt == KIND_TAG) ? job_r.payload_size : '0;
      out_ch.tag_time        <= (kind_nxt == KIND_TAG) ? job_r.tag_time : '0;
      out_ch.tail_word       <= (kind_nxt == KIND_TAG) ? job_r.tail_word : '0;
      out_ch.first_payload   <= (kind_nxt == KIND_TAG) ? job_r.data : '0;
      out_ch.signature_bytes <= (kind_nxt == KIND_HDR) ? job_r.fh[71:48] : '0;
      out_ch.format_version  <= (kind_nxt == KIND_HDR) ? job_r.fh[47:40] : '0;
      out_ch.header_flags    <= (kind_nxt == KIND_HDR) ? job_r.fh[39:32] : '0;
      out_ch.data_start      <= (kind_nxt == KIND_HDR) ? job_r.fh[31:0] : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.last_of_run = last_r;

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> job_r.flags != '0)
    else $error("held job owes no result");
  a_replay_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> rep_cnt_r < 4'(REPLAY_LEN))
    else $error("header replay ran past its length");
  a_hdr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_HDR |-> last_r)
    else $error("header info not the only result of its byte");

endmodule

FILE: design/flv_tag_demultiplexer.sv
// Top level of the FLV tag demultiplexer: byte parser feeding a result sequencer.
// Depends on flvd_pkg, flvd_in_if, flvd_out_if, flvd_parser and flvd_emitter.
// Each result is registered in the sequencer's job register, then its output register;
// with the output not stalled, single-result or result-free bytes flow at one per cycle,
// and a beat with more results, such as a header replay, holds input until all are out.
// Reset (rst_n low, synchronous) clears parse state and both enables.
module flv_tag_demultiplexer (
  input  logic                            clk,
  input  logic                            rst_n,
  flvd_in_if.sink                         in_ch,
  flvd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [flvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flvd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import flvd_pkg::*;

  job_t job;
  logic job_ready;

  flvd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job       (job),
    .job_ready (job_ready)
  );

  flvd_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: test/tb_flv_tag_demultiplexer.sv
// Self-checking testbench for flv_tag_demultiplexer: streams FLV files byte by byte and
// compares each result beat against a cycle-free parser model kept in this file.
// Depends on flvd_pkg, flvd_in_if, flvd_out_if and the flv_tag_demultiplexer RTL.
module tb_flv_tag_demultiplexer;
  import flvd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_TICKS = 10;
  localparam int unsigned DRAIN_TICKS  = 30;
  localparam int unsigned TOTAL_BYTES  = 180;

  typedef enum logic [2:0] {
    ST_FILE_HDR, ST_SKIP, ST_BACKPTR, ST_BACKPTR_VID, ST_TAG_HDR, ST_PAYLOAD
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  tag_kind;
    logic [23:0] size;
    logic [23:0] ts;
    logic [31:0] tail;
    logic [7:0]  first;
    logic [23:0] sig;
    logic [7:0]  ver;
    logic [7:0]  flags;
    logic [31:0] offset;
    logic        last;
  } flv_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  flvd_in_if  in_if ();
  flvd_out_if out_if ();

  flv_tag_demultiplexer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Parser model state.
  parse_state_t parse_state;
  logic [31:0]  pos;
  logic [7:0]   fhdr [FILE_HDR_LEN];
  logic [7:0]   thdr [TAG_HDR_LEN];
  logic [23:0]  remaining;
  logic         vid_started;
  logic         audio_en;
  logic         video_en;

  flv_result_t  step_rows[$];
  flv_result_t  pending_results[$];
  logic [7:0]   file_bytes[$];

  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  bytes_sent;
  int unsigned  stall_left;
  bit           input_bursty;
  bit           sink_stalls;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic flv_result_t blank_result(kind_t k);
    flv_result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic logic reportable_tag(logic [7:0] t);
    return t == TAG_AUDIO || t == TAG_VIDEO || t == TAG_SCRIPT;
  endfunction

  function automatic logic [23:0] tag_len();
    return {thdr[1], thdr[2], thdr[3]};
  endfunction

  function automatic void queue_tag_info(logic [7:0] first);
    flv_result_t r;
    r = blank_result(KIND_TAG);
    r.tag_kind = thdr[0];
    r.size     = tag_len();
    r.ts       = {thdr[4], thdr[5], thdr[6]};
    r.tail     = {thdr[7], thdr[8], thdr[9], thdr[10]};
    r.first    = first;
    step_rows.push_back(r);
  endfunction

  // The first video byte of a file is preceded by the saved file header
  // and a zero back-pointer, so the output is a playable stream on its own.
  function automatic void queue_video_byte(logic [7:0] b);
    flv_result_t r;
    if (!video_en) return;
    if (!vid_started) begin
      vid_started = 1'b1;
      for (int i = 0; i < FILE_HDR_LEN; i++) begin
        r = blank_result(KIND_VIDEO);
        r.data = fhdr[i];
        step_rows.push_back(r);
      end
      for (int i = 0; i < BACKPTR_LEN; i++) step_rows.push_back(blank_result(KIND_VIDEO));
    end
    r = blank_result(KIND_VIDEO);
    r.data = b;
    step_rows.push_back(r);
  endfunction

  function automatic void parse_flv_byte(logic [7:0] b, logic sof);
    logic [31:0] ofs;
    logic [7:0]  t;
    logic        first_byte;
    flv_result_t r;
    step_rows.delete();
    if (sof) begin
      parse_state = ST_FILE_HDR;
      pos         = 0;
      remaining   = 0;
      vid_started = 1'b0;
    end
    case (parse_state)
      ST_FILE_HDR: begin
        fhdr[pos] = b;
        pos++;
        if (pos >= FILE_HDR_LEN) begin
          ofs      = {fhdr[5], fhdr[6], fhdr[7], fhdr[8]};
          r        = blank_result(KIND_HDR);
          r.sig    = {fhdr[0], fhdr[1], fhdr[2]};
          r.ver    = fhdr[3];
          r.flags  = fhdr[4];
          r.offset = ofs;
          step_rows.push_back(r);
          if (ofs < FILE_HDR_LEN) ofs = FILE_HDR_LEN;
          pos = ofs - FILE_HDR_LEN;
          parse_state = (pos != 0) ? ST_SKIP : ST_BACKPTR;
        end
      end
      ST_SKIP: begin
        pos--;
        if (pos == 0) parse_state = ST_BACKPTR;
      end
      ST_BACKPTR, ST_BACKPTR_VID: begin
        // A zero-size tag reports its info on the first back-pointer byte.
        if (remaining != 0 && pos == 0) begin
          queue_tag_info(b);
          remaining = 0;
        end
        if (parse_state == ST_BACKPTR_VID) queue_video_byte(b);
        pos++;
        if (pos >= BACKPTR_LEN) begin
          pos         = 0;
          remaining   = 0;
          parse_state = ST_TAG_HDR;
        end
      end
      ST_TAG_HDR: begin
        thdr[pos] = b;
        if (thdr[0] == TAG_VIDEO) queue_video_byte(b);
        pos++;
        if (pos >= TAG_HDR_LEN) begin
          t         = thdr[0];
          pos       = 0;
          remaining = tag_len();
          if (remaining != 0) begin
            parse_state = ST_PAYLOAD;
          end else begin
            remaining   = reportable_tag(t) ? 24'd1 : 24'd0;
            parse_state = (t == TAG_VIDEO) ? ST_BACKPTR_VID : ST_BACKPTR;
          end
        end
      end
      default: begin
        t          = thdr[0];
        first_byte = (remaining == tag_len());
        if (first_byte && reportable_tag(t)) queue_tag_info(b);
        if (t == TAG_AUDIO) begin
          if (!first_byte && audio_en) begin
            r = blank_result(KIND_AUDIO);
            r.data = b;
            step_rows.push_back(r);
          end
        end else if (t == TAG_VIDEO) begin
          queue_video_byte(b);
        end
        remaining = remaining - 24'd1;
        if (remaining == 0) begin
          pos         = 0;
          parse_state = (t == TAG_VIDEO) ? ST_BACKPTR_VID : ST_BACKPTR;
        end
      end
    endcase
    if (step_rows.size() != 0) step_rows[step_rows.size()-1].last = 1'b1;
    foreach (step_rows[i]) pending_results.push_back(step_rows[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    flv_result_t got;
    flv_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind   = kind_t'(out_if.result_kind);
      got.data   = out_if.out_byte;
      got.tag_kind = out_if.tag_kind;
      got.size   = out_if.payload_size;
      got.ts     = out_if.tag_time;
      got.tail   = out_if.tail_word;
      got.first  = out_if.first_payload;
      got.sig    = out_if.signature_bytes;
      got.ver    = out_if.format_version;
      got.flags  = out_if.header_flags;
      got.offset = out_if.data_start;
      got.last   = out_if.last_of_run;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got kind %0d byte %0h",
                 $time, got.kind, got.data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(out_if.result_kind));
        check_field("out_byte", 32'(want.data), 32'(got.data));
        check_field("tag_kind", 32'(want.tag_kind), 32'(got.tag_kind));
        check_field("payload_size", 32'(want.size), 32'(got.size));
        check_field("tag_time", 32'(want.ts), 32'(got.ts));
        check_field("tail_word", want.tail, got.tail);
        check_field("first_payload", 32'(want.first), 32'(got.first));
        check_field("signature_bytes", 32'(want.sig), 32'(got.sig));
        check_field("format_version", 32'(want.ver), 32'(got.ver));
        check_field("header_flags", 32'(want.flags), 32'(got.flags));
        check_field("data_start", want.offset, got.offset);
        check_field("last_of_run", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Result sink: mostly ready, with short stalls and the odd long one.
  initial begin
    int unsigned roll;
    out_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!sink_stalls) begin
        out_if.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          out_if.ready <= 1'b1;
        end else if (roll < 93) begin
          out_if.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_if.ready <= 1'b0;
          stall_left = $urandom_range(8, 20);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (input_bursty) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic send_byte(logic [7:0] b, logic sof);
    int unsigned gap;
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.stream_byte   <= b;
    in_if.start_of_file <= sof;
    do @(posedge clk); while (!in_if.ready);
    parse_flv_byte(b, sof);
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Stop feeding and let every owed result come out, then wait SETTLE_TICKS more for
  // any byte still in flight that produces nothing.
  task automatic settle_outputs();
    pause_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_AUDIO_EN) audio_en = val[0];
    else if (idx == CFG_VIDEO_EN) video_en = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_enables(logic aud, logic vid);
    settle_outputs();
    write_cfg(CFG_AUDIO_EN, aud);
    write_cfg(CFG_VIDEO_EN, vid);
  endtask

  // ---------------------------------------------------------------- file builder

  function automatic void put_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_header(logic [23:0] sig, logic [7:0] ver, logic [7:0] flags,
                                     logic [31:0] ofs);
    file_bytes.push_back(sig[23:16]);
    file_bytes.push_back(sig[15:8]);
    file_bytes.push_back(sig[7:0]);
    file_bytes.push_back(ver);
    file_bytes.push_back(flags);
    put_word(ofs);
  endfunction

  // A tag whose body is shorter than its size is cut off and gets no back-pointer.
  function automatic void put_tag(logic [7:0] kind, logic [23:0] size, int unsigned body);
    logic [23:0] ts;
    logic [31:0] tail;
    ts   = 24'($urandom);
    tail = $urandom;
    file_bytes.push_back(kind);
    file_bytes.push_back(size[23:16]);
    file_bytes.push_back(size[15:8]);
    file_bytes.push_back(size[7:0]);
    file_bytes.push_back(ts[23:16]);
    file_bytes.push_back(ts[15:8]);
    file_bytes.push_back(ts[7:0]);
    put_word(tail);
    put_random(body);
    if (body == size) put_word(TAG_HDR_LEN + size);
  endfunction

  task automatic send_file(logic with_sof);
    foreach (file_bytes[i]) send_byte(file_bytes[i], with_sof && i == 0);
    bytes_sent += file_bytes.size();
    file_bytes.delete();
  endtask

  // ---------------------------------------------------------------- tests

  // Header reporting with the enables at their reset value: an offset below
  // the header length followed by a zero-size audio tag, the largest offset,
  // and an offset with bytes to skip.
  task automatic test_header_parsing();
    input_bursty = 1'b1;
    sink_stalls  = 1'b0;
    put_header(24'h464C56, 8'h01, 8'h05, 32'd0);
    put_word(32'd0);
    put_tag(TAG_AUDIO, 24'd0, 0);
    send_file(1'b0);
    put_header(24'hFFFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF);
    put_random(3);
    send_file(1'b1);
    put_header(24'h000000, 8'h00, 8'h00, 32'd12);
    put_random(3);
    send_file(1'b1);
  endtask

  task automatic test_audio_output();
    input_bursty = 1'b0;
    sink_stalls  = 1'b1;
    set_enables(1'b1, 1'b0);
    put_header(24'h464C56, 8'h01, 8'h04, 32'd9);
    put_word(32'd0);
    put_tag(TAG_AUDIO, 24'd3, 3);
    send_file(1'b1);
  endtask

  // Video re-emission with a zero-size video tag as the very first tag, which
  // makes one byte produce the full header replay, then a tag with payload.
  task automatic test_video_stream();
    input_bursty = 1'b0;
    sink_stalls  = 1'b1;
    set_enables(1'b1, 1'b1);
    put_header(24'h464C56, 8'h01, 8'h05, 32'd9);
    put_word(32'd0);
    put_tag(TAG_VIDEO, 24'd0, 0);
    put_tag(TAG_VIDEO, 24'd2, 2);
    send_file(1'b1);
  endtask

  // A restart must drop any partial state: mid header, and mid payload of a
  // maximum-size video tag.
  task automatic test_restart_and_truncation();
    input_bursty = 1'b0;
    sink_stalls  = 1'b1;
    put_random(4);
    send_file(1'b1);
    put_header(24'h464C56, 8'h01, 8'h05, 32'd9);
    put_word(32'd0);
    put_tag(TAG_VIDEO, 24'hFFFFFF, 1);
    send_file(1'b1);
  endtask

  function automatic logic [7:0] random_tag_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return TAG_AUDIO;
    if (roll < 70) return TAG_VIDEO;
    if (roll < 85) return TAG_SCRIPT;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] random_tag_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 24'd0;
    if (roll < 90) return 24'($urandom_range(1, 8));
    return 24'($urandom_range(9, 24));
  endfunction

  function automatic void build_random_file();
    int unsigned roll;
    int unsigned ntags;
    logic [23:0] size;
    logic [31:0] ofs;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      put_random($urandom_range(5, 20));
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) ofs = 9;
    else if (roll < 75) ofs = $urandom_range(0, 8);
    else if (roll < 95) ofs = $urandom_range(10, 14);
    else ofs = $urandom;
    put_header(24'($urandom), 8'($urandom), 8'($urandom), ofs);
    if (ofs > 14) begin
      put_random($urandom_range(1, 4));
      return;
    end
    if (ofs > FILE_HDR_LEN) put_random(ofs - FILE_HDR_LEN);
    put_word($urandom);
    ntags = $urandom_range(1, 4);
    for (int unsigned i = 0; i < ntags; i++) begin
      size = random_tag_size();
      if (size != 0 && $urandom_range(0, 9) == 0) begin
        put_tag(random_tag_kind(), size, $urandom_range(0, size - 1));
        return;
      end
      put_tag(random_tag_kind(), size, size);
    end
  endfunction

  // Random files fill the run up to its byte budget.
  task automatic test_random_files();
    int unsigned files;
    files = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 99) < 30) begin
        set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      // Once, hold off the sender until the result queue has fully drained.
      if (files == 0) settle_outputs();
      input_bursty = ($urandom_range(0, 99) < 20);
      sink_stalls  = ($urandom_range(0, 99) >= 20);
      build_random_file();
      send_file(1'b1);
      files++;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.stream_byte   <= '0;
    in_if.start_of_file <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    mismatch_count = 0;
    cycle_count    = 0;
    bytes_sent     = 0;
    input_bursty   = 1'b0;
    sink_stalls    = 1'b0;
    parse_state    = ST_FILE_HDR;
    pos            = 0;
    remaining      = 0;
    vid_started    = 1'b0;
    audio_en       = 1'b0;
    video_en       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_header_parsing();
    test_audio_output();
    test_video_stream();
    test_restart_and_truncation();
    test_random_files();

    pause_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
